/* sv/random_walk_msd_engine_unit_defines.svh */
// Assertion macros shared by the random walk engine modules.
// Depends on nothing; included by files that carry assertions.
`ifndef RANDOM_WALK_MSD_ENGINE_UNIT_DEFINES_SVH
`define RANDOM_WALK_MSD_ENGINE_UNIT_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define RWMSD_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property on every clock edge, reset included.
`define RWMSD_CHECK_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/rwmsd_pkg.sv */
// Types, constants and helper functions of the random walk engine.
// Depends on nothing; imported by every module of the block but rwmsd_ram.
package rwmsd_pkg;

   localparam int MAX_WALKERS_DEFAULT = 1048576;
   localparam int MAX_STEPS_DEFAULT   = 65535;

   localparam int MT_N = 624;
   localparam int MT_M = 397;
   localparam int MT_INDEX_WIDTH = 10;
   localparam logic [31:0] MT_MATRIX   = 32'h9908b0df;
   localparam logic [31:0] SEED_MULT   = 32'd1812433253;
   localparam logic [31:0] SEED_RESET  = 32'd42;
   localparam logic [15:0] STEPS_RESET = 16'd1000;
   localparam logic [31:0] DRAW_LIMIT  = 32'd4294967292;
   localparam logic [31:0] DIR_SPAN    = 32'd715827882;

   localparam int SUM_WIDTH  = 52;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_WIDTH  = SUM_WIDTH + FRAC_BITS;
   localparam int MEAN_WIDTH = 48;
   localparam int DONE_WIDTH = 21;
   localparam int POS_WIDTH  = 17;

   localparam int CSR_INDEX_WIDTH = 4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED  = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEPS = 4'd1;

   typedef enum logic [2:0] {
      DIR_XP, DIR_XN, DIR_YP, DIR_YN, DIR_ZP, DIR_ZN
   } dir_type;

   typedef struct packed {
      logic restart;
      logic last_walker;
   } rwmsd_req_type;

   typedef struct packed {
      logic [31:0]           squared_displacement;
      logic [DONE_WIDTH-1:0] walkers_done;
      logic [MEAN_WIDTH-1:0] mean_q16;
      logic                  mean_valid;
   } rwmsd_rsp_type;

   typedef struct packed {
      logic accept;
      logic seed_init;
      logic seed_run;
      logic walk_init;
      logic walk_run;
      logic sq_run;
      logic acc;
      logic div_init;
      logic div_run;
      logic load;
   } rwmsd_cmd_type;

   typedef struct packed {
      logic seed_done;
      logic walk_idle;
      logic sq_done;
      logic div_done;
      logic rsp_busy;
   } rwmsd_status_type;

   function automatic logic [31:0] mt_temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
      return y;
   endfunction

   function automatic dir_type word_to_dir(input logic [31:0] w);
      dir_type d;
      if (w < DIR_SPAN)              d = DIR_XP;
      else if (w < DIR_SPAN * 32'd2) d = DIR_XN;
      else if (w < DIR_SPAN * 32'd3) d = DIR_YP;
      else if (w < DIR_SPAN * 32'd4) d = DIR_YN;
      else if (w < DIR_SPAN * 32'd5) d = DIR_ZP;
      else                           d = DIR_ZN;
      return d;
   endfunction

endpackage

/* sv/rwmsd_ram.sv */
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module rwmsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end
endmodule

/* sv/rwmsd_ctrl.sv */
// Controller state machine of the random walk engine.
// Depends on rwmsd_pkg; drives the datapath through command signals.
module rwmsd_ctrl import rwmsd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_restart,
   output logic             req_ready,
   input  rwmsd_status_type status,
   output rwmsd_cmd_type    cmd
);
   typedef enum logic [3:0] {
      ST_SEED_START, ST_SEED, ST_IDLE, ST_WALK_START, ST_WALK, ST_SQ,
      ST_ACC, ST_DIV_START, ST_DIV, ST_RESULT
   } state_type;

   state_type state_ff;
   logic      walk_pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_SEED_START;
         walk_pending_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_SEED_START: state_ff <= ST_SEED;
            ST_SEED: begin
               if (status.seed_done) begin
                  state_ff        <= walk_pending_ff ? ST_WALK_START : ST_IDLE;
                  walk_pending_ff <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff        <= req_restart ? ST_SEED_START : ST_WALK_START;
                  walk_pending_ff <= req_restart;
               end
            end
            ST_WALK_START: state_ff <= ST_WALK;
            ST_WALK: if (status.walk_idle) state_ff <= ST_SQ;
            ST_SQ: if (status.sq_done) state_ff <= ST_ACC;
            ST_ACC: state_ff <= ST_DIV_START;
            ST_DIV_START: state_ff <= ST_DIV;
            ST_DIV: if (status.div_done) state_ff <= ST_RESULT;
            ST_RESULT: if (!status.rsp_busy) state_ff <= ST_IDLE;
            default: state_ff <= ST_SEED_START;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == ST_IDLE) && req_valid;
      cmd.seed_init = (state_ff == ST_SEED_START);
      cmd.seed_run  = (state_ff == ST_SEED);
      cmd.walk_init = (state_ff == ST_WALK_START);
      cmd.walk_run  = (state_ff == ST_WALK);
      cmd.sq_run    = (state_ff == ST_SQ);
      cmd.acc       = (state_ff == ST_ACC);
      cmd.div_init  = (state_ff == ST_DIV_START);
      cmd.div_run   = (state_ff == ST_DIV);
      cmd.load      = (state_ff == ST_RESULT) && !status.rsp_busy;
   end
endmodule

/* sv/rwmsd_datapath.sv */
// Datapath of the random walk engine: twister, walker, accumulator, divider.
// Depends on rwmsd_pkg, rwmsd_ram and the shared assertion macros.
`include "random_walk_msd_engine_unit_defines.svh"
module rwmsd_datapath import rwmsd_pkg::*; #(
   parameter int MAX_WALKERS = MAX_WALKERS_DEFAULT,
   parameter int MAX_STEPS   = MAX_STEPS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rwmsd_cmd_type              cmd,
   output rwmsd_status_type           status,
   input  rwmsd_req_type              req_word,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rwmsd_rsp_type              rsp_word
);
   localparam int CW = $clog2(MAX_WALKERS + 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_WALKERS);
   localparam logic [15:0] STEPS_MAX = 16'(MAX_STEPS);
   localparam logic [MT_INDEX_WIDTH-1:0] LAST_INDEX = MT_INDEX_WIDTH'(MT_N - 1);
   localparam int DCW = $clog2(NUM_WIDTH);

   logic [31:0] seed_ff;
   logic [15:0] steps_ff;
   logic        last_ff;

   logic [MT_INDEX_WIDTH-1:0] seed_cnt_ff, idx_ff, s2_idx_ff;
   logic [31:0] p_ff, p_in, cur_ff, mix;
   logic        s2_v_ff, issue, commit_ok;
   logic [15:0] rem_ff, rem_after;
   logic [MT_INDEX_WIDTH-1:0] addr_a, addr_b, idx_next;
   logic [MT_INDEX_WIDTH:0]   idx_far;
   logic [31:0] rd_a, rd_b, y, v, t;
   logic        we;
   logic [MT_INDEX_WIDTH-1:0] waddr;
   logic [31:0] wdata;
   logic signed [POS_WIDTH-1:0] x_ff, y_ff, z_ff, sel_pos;
   logic [15:0] mag;
   logic [1:0]  sq_cnt_ff;
   logic [31:0] sq_ff;
   logic [SUM_WIDTH-1:0] sum_ff;
   logic [SUM_WIDTH:0]   sum_wide;
   logic [CW-1:0] count_ff, div_ff, drem_ff;
   logic [CW:0]   trial;
   logic [NUM_WIDTH-1:0]  num_ff;
   logic [MEAN_WIDTH-1:0] quo_ff;
   logic [DCW-1:0] div_cnt_ff;
   logic rsp_valid_ff;
   rwmsd_rsp_type rsp_ff;

   rwmsd_ram #(.WIDTH(32), .DEPTH(MT_N)) u_words (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr_a(addr_a), .raddr_b(addr_b), .rdata_a(rd_a), .rdata_b(rd_b)
   );

   always_comb begin
      mix  = p_ff ^ (p_ff >> 30);
      p_in = mix * SEED_MULT + 32'(seed_cnt_ff) + 32'd1;
      idx_next = (idx_ff == LAST_INDEX) ? '0 : idx_ff + 1'b1;
      idx_far  = {1'b0, idx_ff} + (MT_INDEX_WIDTH + 1)'(MT_M);
      addr_a   = idx_next;
      addr_b   = (idx_far >= (MT_INDEX_WIDTH + 1)'(MT_N)) ?
                 MT_INDEX_WIDTH'(idx_far - (MT_INDEX_WIDTH + 1)'(MT_N)) :
                 idx_far[MT_INDEX_WIDTH-1:0];
      y = {cur_ff[31], rd_a[30:0]};
      v = rd_b ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 32'd0);
      t = mt_temper(v);
      commit_ok = s2_v_ff && (t < DRAW_LIMIT);
      rem_after = rem_ff - (commit_ok ? 16'd1 : 16'd0);
      issue = cmd.walk_run && (rem_after != 16'd0);
      we    = cmd.seed_run || s2_v_ff;
      waddr = cmd.seed_run ? seed_cnt_ff : s2_idx_ff;
      wdata = cmd.seed_run ? p_ff : v;
      case (sq_cnt_ff)
         2'd0:    sel_pos = x_ff;
         2'd1:    sel_pos = y_ff;
         default: sel_pos = z_ff;
      endcase
      mag = sel_pos[POS_WIDTH-1] ? 16'(-sel_pos) : sel_pos[15:0];
      sum_wide = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(sq_ff);
      trial = {drem_ff, num_ff[NUM_WIDTH-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_RESET;
         steps_ff     <= STEPS_RESET;
         s2_v_ff      <= 1'b0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_valid && csr_index == CSR_SEED)  seed_ff  <= csr_data;
         if (csr_valid && csr_index == CSR_STEPS) steps_ff <= csr_data[15:0];
         s2_v_ff <= issue;
         if (cmd.walk_init) begin
            rem_ff <= (steps_ff > STEPS_MAX) ? STEPS_MAX : steps_ff;
         end else begin
            rem_ff <= rem_after;
         end
         if (cmd.seed_init) begin
            sum_ff   <= '0;
            count_ff <= '0;
         end else if (cmd.acc && count_ff < COUNT_MAX) begin
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
         end
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) last_ff <= req_word.last_walker;
      if (cmd.seed_init) begin
         p_ff        <= seed_ff;
         cur_ff      <= seed_ff;
         seed_cnt_ff <= '0;
         idx_ff      <= '0;
      end else if (cmd.seed_run) begin
         p_ff        <= p_in;
         seed_cnt_ff <= seed_cnt_ff + 1'b1;
      end
      if (issue) begin
         idx_ff    <= idx_next;
         s2_idx_ff <= idx_ff;
      end
      if (s2_v_ff) cur_ff <= rd_a;
      if (cmd.walk_init) begin
         x_ff <= '0;
         y_ff <= '0;
         z_ff <= '0;
         sq_cnt_ff <= '0;
         sq_ff <= '0;
      end else if (commit_ok) begin
         unique case (word_to_dir(t))
            DIR_XP:  x_ff <= x_ff + 1'sb1;
            DIR_XN:  x_ff <= x_ff - 1'sb1;
            DIR_YP:  y_ff <= y_ff + 1'sb1;
            DIR_YN:  y_ff <= y_ff - 1'sb1;
            DIR_ZP:  z_ff <= z_ff + 1'sb1;
            default: z_ff <= z_ff - 1'sb1;
         endcase
      end else if (cmd.sq_run) begin
         sq_ff     <= sq_ff + 32'(mag) * 32'(mag);
         sq_cnt_ff <= sq_cnt_ff + 1'b1;
      end
      if (cmd.div_init) begin
         div_ff     <= count_ff;
         drem_ff    <= '0;
         num_ff     <= {sum_ff, {FRAC_BITS{1'b0}}};
         div_cnt_ff <= '0;
      end else if (cmd.div_run) begin
         num_ff     <= num_ff << 1;
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (trial >= {1'b0, div_ff}) begin
            drem_ff <= CW'(trial - {1'b0, div_ff});
            quo_ff  <= {quo_ff[MEAN_WIDTH-2:0], 1'b1};
         end else begin
            drem_ff <= trial[CW-1:0];
            quo_ff  <= {quo_ff[MEAN_WIDTH-2:0], 1'b0};
         end
      end
      if (cmd.load) begin
         rsp_ff.squared_displacement <= sq_ff;
         rsp_ff.walkers_done         <= DONE_WIDTH'(32'(count_ff));
         rsp_ff.mean_q16             <= quo_ff;
         rsp_ff.mean_valid           <= last_ff;
      end
   end

   assign status.seed_done = cmd.seed_run && (seed_cnt_ff == LAST_INDEX);
   assign status.walk_idle = (rem_ff == 16'd0) && !s2_v_ff;
   assign status.sq_done   = cmd.sq_run && (sq_cnt_ff == 2'd2);
   assign status.div_done  = cmd.div_run && (div_cnt_ff == DCW'(NUM_WIDTH - 1));
   assign status.rsp_busy  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `RWMSD_CHECK(a_commit_has_step, clock, reset, s2_v_ff |-> rem_ff != 16'd0,
      "draw committed with no step left")
   `RWMSD_CHECK(a_count_bound, clock, reset, count_ff <= COUNT_MAX,
      "walker count above its limit")
   `RWMSD_CHECK(a_divisor_nonzero, clock, reset, cmd.div_run |-> div_ff != '0,
      "division started with a zero walker count")
   `RWMSD_CHECK(a_load_free, clock, reset, cmd.load |-> !status.rsp_busy,
      "result loaded over a word not yet taken")
endmodule

/* sv/random_walk_msd_engine_unit.sv */
// Top level of the lattice random walk mean squared displacement engine.
// Depends on rwmsd_pkg, rwmsd_ctrl, rwmsd_datapath and rwmsd_ram.
//
// Each request word runs one walker of steps_per_walker unit steps on the
// 3D lattice and yields one response word with the squared end distance,
// the walker count since restart and the running mean in Q16.
// Requests use req_valid/req_ready, responses rsp_valid/rsp_ready, and the
// csr channel writes seed (index 0) and steps_per_walker (index 1); csr is
// always ready and other indexes are ignored.
// One request is processed at a time. After a start step the walker takes
// one generator draw per cycle from the twister memory, rejected draws
// included, through a pipeline that fills and drains around them; then
// come the squares, the accumulate step, the bit-serial mean divider and
// the load and idle steps. A request with restart set first reseeds the
// generator in a full sweep of the twister memory.
// After reset the generator is seeded from seed 42 in the same sweep;
// req_ready stays low until it completes.
// A finished response waits in the output register while the receiver
// stalls; the next request is accepted and runs, and its result waits
// until the earlier word is taken.
module random_walk_msd_engine_unit import rwmsd_pkg::*; #(
   parameter int MAX_WALKERS = MAX_WALKERS_DEFAULT,
   parameter int MAX_STEPS   = MAX_STEPS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  rwmsd_req_type              req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rwmsd_rsp_type              rsp_word,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0]                csr_data
);
   rwmsd_cmd_type    cmd;
   rwmsd_status_type status;

   assign csr_ready = 1'b1;

   rwmsd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_restart(req_word.restart), .req_ready(req_ready),
      .status(status), .cmd(cmd)
   );

   rwmsd_datapath #(.MAX_WALKERS(MAX_WALKERS), .MAX_STEPS(MAX_STEPS)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_word(req_word), .csr_valid(csr_valid && csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );
endmodule

/* test/random_walk_msd_engine_unit_test.sv */
// Self-checking testbench for the lattice random walk mean squared displacement engine.
// Depends on rwmsd_pkg and random_walk_msd_engine_unit; holds its own twister and walk predictor.
`timescale 1ns / 100ps

module random_walk_msd_engine_unit_test;
   import rwmsd_pkg::*;

   localparam int WALKER_CAP = MAX_WALKERS_DEFAULT;
   localparam int STEP_CAP = 65535;
   localparam int WATCHDOG_LIMIT = 300000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 4'd15;

   typedef struct {
      logic [31:0]   seed;
      logic [15:0]   steps;
      bit            restart;
      bit            last_walker;
      bit            typed;
      rwmsd_rsp_type result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rwmsd_req_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rwmsd_rsp_type rsp_word;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   rwmsd_rsp_type pending_results[$];
   int mismatches = 0;
   int idle_cycles = 0;
   int send_gap_pct = 0;
   int take_stall_pct = 0;

   logic [31:0] seed_reg = SEED_RESET;
   logic [15:0] steps_reg = STEPS_RESET;
   logic [31:0] mt_state[MT_N];
   int mt_pos;
   logic [51:0] msd_sum;
   logic [20:0] msd_count;

   random_walk_msd_engine_unit #(.MAX_WALKERS(WALKER_CAP), .MAX_STEPS(STEP_CAP)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic twister_seed(input logic [31:0] s);
      mt_state[0] = s;
      for (int i = 1; i < MT_N; i++) begin
         mt_state[i] = SEED_MULT * (mt_state[i-1] ^ (mt_state[i-1] >> 30)) + i;
      end
      mt_pos = MT_N;
   endtask

   task automatic twister_word(output logic [31:0] y);
      logic [31:0] t;
      logic [31:0] v;
      if (mt_pos >= MT_N) begin
         for (int i = 0; i < MT_N; i++) begin
            t = (mt_state[i] & 32'h80000000) | (mt_state[(i + 1) % MT_N] & 32'h7fffffff);
            v = mt_state[(i + MT_M) % MT_N] ^ (t >> 1);
            if (t[0]) begin
               v = v ^ MT_MATRIX;
            end
            mt_state[i] = v;
         end
         mt_pos = 0;
      end
      y = mt_state[mt_pos];
      mt_pos++;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & 32'h9d2c5680);
      y = y ^ ((y << 15) & 32'hefc60000);
      y = y ^ (y >> 18);
   endtask

   task automatic predict_walker(input rwmsd_req_type w, output rwmsd_rsp_type r);
      logic [31:0] word;
      int px, py, pz, n;
      logic [63:0] sq;
      logic [67:0] mean;
      px = 0;
      py = 0;
      pz = 0;
      if (w.restart) begin
         twister_seed(seed_reg);
         msd_sum = '0;
         msd_count = '0;
      end
      n = (steps_reg > STEP_CAP) ? STEP_CAP : steps_reg;
      for (int s = 0; s < n; s++) begin
         do begin
            twister_word(word);
         end while (word >= DRAW_LIMIT);
         case (dir_type'(word / DIR_SPAN))
            DIR_XP: px++;
            DIR_XN: px--;
            DIR_YP: py++;
            DIR_YN: py--;
            DIR_ZP: pz++;
            default: pz--;
         endcase
      end
      sq = px * px + py * py + pz * pz;
      if (msd_count < WALKER_CAP) begin
         msd_count++;
         if ({12'd0, msd_sum} + sq > 64'h000fffffffffffff) begin
            msd_sum = '1;
         end else begin
            msd_sum = msd_sum + sq;
         end
      end
      if (msd_count == 0) begin
         mean = '0;
      end else begin
         mean = ({16'd0, msd_sum} / msd_count << 16)
            + ((({16'd0, msd_sum} % msd_count) << 16) / msd_count);
      end
      r.squared_displacement = sq[31:0];
      r.walkers_done = msd_count;
      r.mean_q16 = mean[47:0];
      r.mean_valid = w.last_walker;
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SEED) begin
         seed_reg = d;
      end else if (idx == CSR_STEPS) begin
         steps_reg = d[15:0];
      end
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_walker(input bit restart, input bit last_walker, input bit typed,
                              input rwmsd_rsp_type typed_result);
      rwmsd_req_type w;
      rwmsd_rsp_type r;
      w.restart = restart;
      w.last_walker = last_walker;
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_walker(w, r);
      pending_results.push_back(typed ? typed_result : r);
   endtask

   always @(posedge clock) begin
      rwmsd_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= take_stall_pct);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Unexpected word: %p", rsp_word);
               end
            end else begin
               want = pending_results.pop_front();
               if (rsp_word !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch: expected %p, got %p", want, rsp_word);
                  end
               end
            end
         end
      end
   end

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      rwmsd_rsp_type none;
      none = '0;
      twister_seed(SEED_RESET);
      msd_sum = '0;
      msd_count = '0;
      rows = '{
         '{32'd42, 16'd0, 1, 0, 1, '{32'd0, 21'd1, 48'd0, 1'b0}},
         '{32'd42, 16'd0, 0, 1, 1, '{32'd0, 21'd2, 48'd0, 1'b1}},
         '{32'd42, 16'd0, 1, 1, 1, '{32'd0, 21'd1, 48'd0, 1'b1}},
         '{32'd42, 16'd1, 1, 0, 1, '{32'd1, 21'd1, 48'd65536, 1'b0}},
         '{32'd42, 16'd1, 0, 0, 1, '{32'd1, 21'd2, 48'd65536, 1'b0}},
         '{32'd42, 16'd1, 0, 1, 1, '{32'd1, 21'd3, 48'd65536, 1'b1}},
         '{32'd0, 16'd5, 1, 0, 0, none},
         '{32'd0, 16'd5, 0, 0, 0, none},
         '{32'hffffffff, 16'd5, 0, 1, 0, none},
         '{32'hffffffff, 16'd5, 1, 0, 0, none},
         '{32'd42, 16'd65535, 1, 1, 0, none},
         '{32'd42, 16'd1000, 0, 0, 0, none}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 6;
      take_stall_pct = 64;
      send_walker(0, 0, 0, none);
      drain_results();
      write_register(CSR_UNUSED, 32'hffffffff);
      foreach (rows[i]) begin
         row = rows[i];
         if (row.seed != seed_reg || row.steps != steps_reg) begin
            drain_results();
            write_register(CSR_SEED, row.seed);
            write_register(CSR_STEPS, {16'd0, row.steps});
         end
         send_walker(row.restart, row.last_walker, row.typed, row.result);
      end
      for (int phase = 0; phase < 6; phase++) begin
         send_gap_pct = (phase < 2) ? 6 : (phase < 4) ? 64 : 0;
         take_stall_pct = (phase < 2) ? 64 : (phase < 4) ? 6 : 0;
         drain_results();
         write_register(CSR_SEED, $urandom);
         write_register(CSR_STEPS, (phase == 3) ? $urandom_range(200, 400)
                                                : $urandom_range(0, 60));
         for (int k = 0; k < 100; k++) begin
            send_walker($urandom_range(39) == 0, $urandom_range(7) == 0, 0, none);
         end
      end
      drain_results();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
